@@ design/im2col_pkg.sv @@
package im2col_pkg;

    // block constants
    localparam int CHANNELS   = 64;
    localparam int IMAGES     = 1;
    localparam int DIL_ROWS   = 1;
    localparam int DIL_COLS   = 1;
    localparam int KERNEL_MAX = 8;

    // field widths
    localparam int IDX_W     = 32;
    localparam int DIM_W     = 12;
    localparam int KER_W     = 4;
    localparam int PAD_W     = 8;
    localparam int STR_W     = 5;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 3;
    localparam int SRC_W     = 32;
    localparam int DST_W     = 38;

    // derived widths
    localparam int EXT_W   = DIM_W + 1;
    localparam int KK_W    = 2 * KER_W;
    localparam int HW_W    = 2 * DIM_W;
    localparam int PLANE_W = 2 * EXT_W + $clog2(IMAGES) + 1;
    localparam int TOT_W   = PLANE_W + $clog2(CHANNELS) + 1;
    localparam int CI_W    = $clog2(CHANNELS * IMAGES) + 1;
    localparam int POS_W   = 20;
    localparam int SEQ_W   = 5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_ROWS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_COLS      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_ROWS   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_COLS   = 3'd7;

    // configuration and the grid values derived from it
    typedef struct packed {
        logic [DIM_W-1:0]   img_h;
        logic [DIM_W-1:0]   img_w;
        logic [KER_W-1:0]   kh_raw;
        logic [KER_W-1:0]   kw_raw;
        logic [PAD_W-1:0]   pr;
        logic [PAD_W-1:0]   pc;
        logic [STR_W-1:0]   sr_raw;
        logic [STR_W-1:0]   sc_raw;
        logic [KER_W-1:0]   kh;
        logic [KER_W-1:0]   kw;
        logic [STR_W-1:0]   sr;
        logic [STR_W-1:0]   sc;
        logic [EXT_W-1:0]   hc;
        logic [EXT_W-1:0]   wc;
        logic [KK_W-1:0]    khkw;
        logic [HW_W-1:0]    hw;
        logic [PLANE_W-1:0] plane_raw;
        logic [PLANE_W-1:0] plane;
        logic [TOT_W-1:0]   total;
    } t_geom;

    // one divider stage word
    typedef struct packed {
        logic             valid;
        logic             oor;
        logic [IDX_W-1:0] num;
        logic [EXT_W-1:0] rem;
        logic [EXT_W-1:0] side;
    } t_div;

    // address build stages
    typedef struct packed {
        logic                    valid;
        logic                    oor;
        logic [EXT_W-1:0]        w;
        logic [EXT_W-1:0]        h;
        logic [CI_W-1:0]         b;
        logic [CI_W-1:0]         c;
        logic signed [POS_W-1:0] row0;
        logic signed [POS_W-1:0] col0;
        logic [DST_W-1:0]        m1;
        logic [CI_W-1:0]         bc;
        logic [SRC_W-1:0]        rw;
        logic [DST_W-1:0]        t1;
        logic [SRC_W-1:0]        base;
        logic [DST_W-1:0]        t2;
        logic [SRC_W-1:0]        row_addr;
        logic [DST_W-1:0]        dest;
    } t_post;

    function automatic logic [KER_W-1:0] clamp_kernel(input logic [KER_W-1:0] k);
        logic [KER_W-1:0] res;
        res = k;
        if (k == '0) res = KER_W'(1);
        else if (k > KER_W'(KERNEL_MAX)) res = KER_W'(KERNEL_MAX);
        return res;
    endfunction

endpackage

@@ design/im2col_divpipe.sv @@
module im2col_divpipe
    import im2col_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  t_div             i_in,
    input  logic [EXT_W-1:0] i_divisor,
    output t_div             o_out
);

    // one quotient bit per stage, restoring
    t_div r_st [IDX_W];
    t_div n_st [IDX_W];

    always_comb begin
        t_div             prev;
        logic [EXT_W:0]   sh;
        logic             ge;
        for (int s = 0; s < IDX_W; s++) begin
            prev = (s == 0) ? i_in : r_st[(s == 0) ? 0 : s - 1];
            sh = {prev.rem, prev.num[IDX_W-1]};
            ge = (sh >= {1'b0, i_divisor});
            n_st[s] = prev;
            n_st[s].rem = ge ? EXT_W'(sh - {1'b0, i_divisor}) : EXT_W'(sh);
            n_st[s].num = {prev.num[IDX_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < IDX_W; s++) r_st[s].valid <= 1'b0;
        end else if (i_adv) begin
            for (int s = 0; s < IDX_W; s++) r_st[s] <= n_st[s];
        end
    end

    assign o_out = r_st[IDX_W-1];

endmodule

@@ design/im2col_cfg.sv @@
module im2col_cfg
    import im2col_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_geom                o_geom,
    output logic                 o_ready
);

    localparam logic [SEQ_W-1:0] SEQ_GRID  = SEQ_W'(EXT_W + 1);
    localparam logic [SEQ_W-1:0] SEQ_MUL   = SEQ_W'(EXT_W + 2);
    localparam logic [SEQ_W-1:0] SEQ_PLANE = SEQ_W'(EXT_W + 3);
    localparam logic [SEQ_W-1:0] SEQ_LAST  = SEQ_W'(EXT_W + 4);

    t_geom            r_geom;
    logic             r_busy;
    logic [SEQ_W-1:0] r_cnt;
    logic [EXT_W-1:0] r_num_r, r_num_c;
    logic [STR_W-1:0] r_rem_r, r_rem_c;
    logic             r_zero_r, r_zero_c;

    logic [EXT_W-1:0] pad_r, pad_c, span_r, span_c;
    logic [KER_W-1:0] kh_c, kw_c;
    logic [STR_W:0]   sh_r, sh_c;
    logic             ge_r, ge_c;

    always_comb begin
        kh_c   = clamp_kernel(r_geom.kh_raw);
        kw_c   = clamp_kernel(r_geom.kw_raw);
        pad_r  = EXT_W'(r_geom.img_h) + EXT_W'({r_geom.pr, 1'b0});
        pad_c  = EXT_W'(r_geom.img_w) + EXT_W'({r_geom.pc, 1'b0});
        span_r = EXT_W'(DIL_ROWS * (kh_c - KER_W'(1))) + EXT_W'(1);
        span_c = EXT_W'(DIL_COLS * (kw_c - KER_W'(1))) + EXT_W'(1);
        sh_r   = {r_rem_r, r_num_r[EXT_W-1]};
        sh_c   = {r_rem_c, r_num_c[EXT_W-1]};
        ge_r   = (sh_r >= {1'b0, r_geom.sr});
        ge_c   = (sh_c >= {1'b0, r_geom.sc});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.img_h  <= DIM_W'(32);
            r_geom.img_w  <= DIM_W'(32);
            r_geom.kh_raw <= KER_W'(3);
            r_geom.kw_raw <= KER_W'(3);
            r_geom.pr     <= PAD_W'(1);
            r_geom.pc     <= PAD_W'(1);
            r_geom.sr_raw <= STR_W'(1);
            r_geom.sc_raw <= STR_W'(1);
            r_busy        <= 1'b1;
            r_cnt         <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_HEIGHT:  r_geom.img_h  <= i_cfg_data[DIM_W-1:0];
                REG_IMAGE_WIDTH:   r_geom.img_w  <= i_cfg_data[DIM_W-1:0];
                REG_KERNEL_HEIGHT: r_geom.kh_raw <= i_cfg_data[KER_W-1:0];
                REG_KERNEL_WIDTH:  r_geom.kw_raw <= i_cfg_data[KER_W-1:0];
                REG_PAD_ROWS:      r_geom.pr     <= i_cfg_data[PAD_W-1:0];
                REG_PAD_COLS:      r_geom.pc     <= i_cfg_data[PAD_W-1:0];
                REG_STRIDE_ROWS:   r_geom.sr_raw <= i_cfg_data[STR_W-1:0];
                REG_STRIDE_COLS:   r_geom.sc_raw <= i_cfg_data[STR_W-1:0];
                default: ;
            endcase
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + SEQ_W'(1);
            if (r_cnt == '0) begin
                r_geom.kh <= kh_c;
                r_geom.kw <= kw_c;
                r_geom.sr <= (r_geom.sr_raw == '0) ? STR_W'(1) : r_geom.sr_raw;
                r_geom.sc <= (r_geom.sc_raw == '0) ? STR_W'(1) : r_geom.sc_raw;
                r_zero_r  <= (pad_r < span_r);
                r_zero_c  <= (pad_c < span_c);
                r_num_r   <= pad_r - span_r;
                r_num_c   <= pad_c - span_c;
                r_rem_r   <= '0;
                r_rem_c   <= '0;
            end else if (r_cnt < SEQ_GRID) begin
                // one quotient bit per cycle for both dimensions
                r_rem_r <= ge_r ? STR_W'(sh_r - {1'b0, r_geom.sr}) : STR_W'(sh_r);
                r_rem_c <= ge_c ? STR_W'(sh_c - {1'b0, r_geom.sc}) : STR_W'(sh_c);
                r_num_r <= {r_num_r[EXT_W-2:0], ge_r};
                r_num_c <= {r_num_c[EXT_W-2:0], ge_c};
            end else if (r_cnt == SEQ_GRID) begin
                r_geom.hc <= r_zero_r ? '0 : r_num_r + EXT_W'(1);
                r_geom.wc <= r_zero_c ? '0 : r_num_c + EXT_W'(1);
            end else if (r_cnt == SEQ_MUL) begin
                r_geom.plane_raw <= PLANE_W'(r_geom.hc) * PLANE_W'(r_geom.wc);
                r_geom.hw        <= HW_W'(r_geom.img_h) * HW_W'(r_geom.img_w);
                r_geom.khkw      <= KK_W'(r_geom.kh) * KK_W'(r_geom.kw);
            end else if (r_cnt == SEQ_PLANE) begin
                r_geom.plane <= PLANE_W'(r_geom.plane_raw * IMAGES);
            end else if (r_cnt == SEQ_LAST) begin
                r_geom.total <= TOT_W'(r_geom.plane * CHANNELS);
                r_busy       <= 1'b0;
            end
        end
    end

    assign o_geom  = r_geom;
    assign o_ready = !r_busy;

endmodule

@@ design/im2col_address_generator.sv @@
// im2col address generator. Each column_index transaction yields one result per
// kernel tap in row-major order (kernel_height*kernel_width results, last_tap on
// the final one), or a single out_of_range result when the index is at or beyond
// CHANNELS*IMAGES*out_rows*out_cols. Results leave at one per cycle unless
// i_out_stall holds them, so the tap emitter sets the sustained rate. On the way
// to the first result an index passes an input register, two 32-stage
// pipelined dividers (index by out_cols, then by out_rows), five address build
// stages, the emitter load and the output register. New indexes enter while
// earlier ones are still in the pipe. After reset and after every register
// write, the output grid (two 13-step stride divisions and a few products) is
// recomputed, during which the input is stalled; register writes are taken at
// any time but must only be made while the block is idle.
module im2col_address_generator
    import im2col_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [IDX_W-1:0]     i_column_index,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [SRC_W-1:0]     o_source_address,
    output logic                 o_pad_zero,
    output logic [DST_W-1:0]     o_dest_address,
    output logic                 o_out_of_range,
    output logic                 o_last_tap
);

    t_geom geom;
    logic  cfg_ready;

    im2col_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_geom      (geom),
        .o_ready     (cfg_ready)
    );

    // pipeline control: whole pipe moves together, frozen while the tap
    // emitter cannot take the item sitting in the last stage
    logic adv, accept, out_move, emit, last, free;
    t_div  r_in, d1_out, d2_in, d2_out;
    t_post r_p1, r_p2, r_p3, r_p4, r_p5;
    t_post n_p1, n_p2, n_p3, n_p4, n_p5;

    // tap emitter state
    logic                    r_busy, r_oor;
    logic [KER_W-1:0]        r_i, r_j;
    logic signed [POS_W-1:0] r_r, r_q, r_col0;
    logic [SRC_W-1:0]        r_row_addr;
    logic [DST_W-1:0]        r_dest;

    assign out_move   = !o_out_valid || !i_out_stall;
    assign emit       = r_busy && out_move;
    assign last       = r_oor || (r_i == geom.kh - KER_W'(1) && r_j == geom.kw - KER_W'(1));
    assign free       = !r_busy || (emit && last);
    assign adv        = !r_p5.valid || free;
    assign o_in_stall = !(adv && cfg_ready);
    assign accept     = i_in_valid && !o_in_stall;

    // input register with the range check
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (adv) begin
            r_in.valid <= accept;
            r_in.oor   <= (TOT_W'(i_column_index) >= geom.total);
            r_in.num   <= i_column_index;
            r_in.rem   <= '0;
            r_in.side  <= '0;
        end
    end

    // index / out_cols: remainder is the output column
    im2col_divpipe u_div_col (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_in      (r_in),
        .i_divisor (geom.wc),
        .o_out     (d1_out)
    );

    always_comb begin
        d2_in      = d1_out;
        d2_in.rem  = '0;
        d2_in.side = d1_out.rem;
    end

    // quotient / out_rows: remainder is the output row
    im2col_divpipe u_div_row (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_in      (d2_in),
        .i_divisor (geom.hc),
        .o_out     (d2_out)
    );

    logic [CI_W-1:0] q2n;
    assign q2n = d2_out.num[CI_W-1:0];

    // address build: pipelined multiplies and adds, spread over the stages
    always_comb begin
        // split off image and channel, first tap position
        n_p1       = '0;
        n_p1.valid = d2_out.valid;
        n_p1.oor   = d2_out.oor;
        n_p1.w     = d2_out.side;
        n_p1.h     = d2_out.rem;
        n_p1.b     = CI_W'(q2n % IMAGES);
        n_p1.c     = CI_W'(q2n / IMAGES);
        n_p1.row0  = POS_W'(d2_out.rem * geom.sr) - POS_W'(geom.pr);
        n_p1.col0  = POS_W'(d2_out.side * geom.sc) - POS_W'(geom.pc);

        n_p2    = r_p1;
        n_p2.m1 = DST_W'(HW_W'(r_p1.c) * HW_W'(geom.khkw));
        n_p2.bc = CI_W'(r_p1.b * CHANNELS) + r_p1.c;
        n_p2.rw = SRC_W'({{(SRC_W-POS_W){r_p1.row0[POS_W-1]}}, r_p1.row0}
                         * SRC_W'(geom.img_w));

        n_p3      = r_p2;
        n_p3.t1   = DST_W'(r_p2.m1 * IMAGES) + DST_W'(r_p2.b);
        n_p3.base = SRC_W'(SRC_W'(r_p2.bc) * SRC_W'(geom.hw));

        // the row-major prefix stays well inside 32 bits
        n_p4          = r_p3;
        n_p4.t2       = DST_W'(SRC_W'(r_p3.t1[SRC_W-1:0]) * SRC_W'(geom.hc))
                      + DST_W'(r_p3.h);
        n_p4.row_addr = r_p3.base + r_p3.rw;

        n_p5      = r_p4;
        n_p5.dest = DST_W'(r_p4.t2[SRC_W-1:0]) * DST_W'(geom.wc) + DST_W'(r_p4.w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1.valid <= 1'b0;
            r_p2.valid <= 1'b0;
            r_p3.valid <= 1'b0;
            r_p4.valid <= 1'b0;
            r_p5.valid <= 1'b0;
        end else if (adv) begin
            r_p1 <= n_p1;
            r_p2 <= n_p2;
            r_p3 <= n_p3;
            r_p4 <= n_p4;
            r_p5 <= n_p5;
        end
    end

    // tap emitter: walks the kernel with adders only
    logic              in_img;
    logic [SRC_W-1:0]  src_addr;

    assign in_img = !r_r[POS_W-1] && !r_q[POS_W-1]
                 && (r_r < POS_W'(geom.img_h)) && (r_q < POS_W'(geom.img_w));
    assign src_addr = r_row_addr + {{(SRC_W-POS_W){r_q[POS_W-1]}}, r_q};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                o_out_valid      <= 1'b1;
                o_out_of_range   <= r_oor;
                o_last_tap       <= last;
                o_pad_zero       <= !r_oor && !in_img;
                o_source_address <= (!r_oor && in_img) ? src_addr : '0;
                o_dest_address   <= r_oor ? '0 : r_dest;
                // step to the next tap; the final tap hands over to the loader
                if (!last) begin
                    r_dest <= r_dest + DST_W'(geom.plane);
                    if (r_j == geom.kw - KER_W'(1)) begin
                        r_j        <= '0;
                        r_i        <= r_i + KER_W'(1);
                        r_q        <= r_col0;
                        r_r        <= r_r + POS_W'(DIL_ROWS);
                        r_row_addr <= r_row_addr
                                    + SRC_W'(SRC_W'(DIL_ROWS) * SRC_W'(geom.img_w));
                    end else begin
                        r_j <= r_j + KER_W'(1);
                        r_q <= r_q + POS_W'(DIL_COLS);
                    end
                end
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end

            if (free) begin
                r_busy <= r_p5.valid;
                if (r_p5.valid) begin
                    r_oor      <= r_p5.oor;
                    r_i        <= '0;
                    r_j        <= '0;
                    r_r        <= r_p5.row0;
                    r_q        <= r_p5.col0;
                    r_col0     <= r_p5.col0;
                    r_row_addr <= r_p5.row_addr;
                    r_dest     <= r_p5.dest;
                end
            end
        end
    end

    // a range miss is always a single closing result with no pad flag
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_of_range |-> o_last_tap && !o_pad_zero && o_dest_address == '0)
        else $error("out of range result malformed");

    // padded taps never carry a source address
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pad_zero |-> o_source_address == '0)
        else $error("padding tap with nonzero source");

    // no index enters while the grid is being recomputed
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !cfg_ready |-> o_in_stall)
        else $error("input taken during grid recompute");

    // a held result is not overwritten by the emitter
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_dest_address))
        else $error("stalled result changed");

endmodule

@@ tb/sv/tb_im2col_address_generator.sv @@
`timescale 1ns / 100ps

module tb_im2col_address_generator;
    import im2col_pkg::*;

    // one expected tap transaction
    typedef struct {
        logic [SRC_W-1:0] src;
        logic             pad;
        logic [DST_W-1:0] dst;
        logic             oor;
        logic             last;
    } t_tap;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [IDX_W-1:0]     i_column_index;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [SRC_W-1:0]     o_source_address;
    logic                 o_pad_zero;
    logic [DST_W-1:0]     o_dest_address;
    logic                 o_out_of_range;
    logic                 o_last_tap;

    im2col_address_generator DUT (.*);

    // shadow copy of the geometry registers
    logic [DIM_W-1:0] img_h, img_w;
    logic [KER_W-1:0] ker_h, ker_w;
    logic [PAD_W-1:0] pad_r, pad_c;
    logic [STR_W-1:0] str_r, str_c;

    logic [IDX_W-1:0] pending_idx[$];
    t_tap             tap_q[$];
    int               send_idle, recv_idle;
    int               fail_cnt, item_cnt, tap_cnt, cfg_cnt, idle_cnt;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // output grid size along one axis
    function automatic longint grid_len(longint extent, longint pad, longint k,
                                        longint dil, longint stride);
        longint padded, span;
        padded = extent + 2 * pad;
        span   = dil * (k - 1) + 1;
        if (padded < span) return 0;
        return (padded - span) / stride + 1;
    endfunction

    function automatic longint eff_kernel(logic [KER_W-1:0] k);
        if (k == 0) return 1;
        if (k > KERNEL_MAX) return KERNEL_MAX;
        return k;
    endfunction

    function automatic longint eff_stride(logic [STR_W-1:0] s);
        return (s == 0) ? 1 : s;
    endfunction

    function automatic longint rows_out();
        return grid_len(img_h, pad_r, eff_kernel(ker_h), DIL_ROWS, eff_stride(str_r));
    endfunction

    function automatic longint cols_out();
        return grid_len(img_w, pad_c, eff_kernel(ker_w), DIL_COLS, eff_stride(str_c));
    endfunction

    // expand one column index into its tap transactions
    function automatic void expand_taps(logic [IDX_W-1:0] idx);
        longint kh, kw, sr, sc, hc, wc, plane, total;
        longint w, h, b, c, row0, col0, r, q, dest, base;
        t_tap   t;
        kh = eff_kernel(ker_h);
        kw = eff_kernel(ker_w);
        sr = eff_stride(str_r);
        sc = eff_stride(str_c);
        hc = rows_out();
        wc = cols_out();
        plane = IMAGES * hc * wc;
        total = CHANNELS * plane;
        if (longint'(idx) >= total || hc == 0 || wc == 0) begin
            t = '{src: '0, pad: 1'b0, dst: '0, oor: 1'b1, last: 1'b1};
            tap_q.push_back(t);
            return;
        end
        w = longint'(idx) % wc;
        h = (longint'(idx) / wc) % hc;
        b = (longint'(idx) / wc / hc) % IMAGES;
        c = (longint'(idx) / wc / hc) / IMAGES;
        row0 = h * sr - longint'(pad_r);
        col0 = w * sc - longint'(pad_c);
        dest = (((c * kh * kw) * IMAGES + b) * hc + h) * wc + w;
        base = (b * CHANNELS + c) * longint'(img_h) * longint'(img_w);
        for (int i = 0; i < kh; i++) begin
            for (int j = 0; j < kw; j++) begin
                r = row0 + i * DIL_ROWS;
                q = col0 + j * DIL_COLS;
                t.oor  = 1'b0;
                t.last = (i == kh - 1) && (j == kw - 1);
                t.dst  = DST_W'(dest);
                if (r >= 0 && q >= 0 && r < img_h && q < img_w) begin
                    t.src = SRC_W'(base + r * longint'(img_w) + q);
                    t.pad = 1'b0;
                end else begin
                    t.src = '0;
                    t.pad = 1'b1;
                end
                tap_q.push_back(t);
                dest += plane;
            end
        end
    endfunction

    // driver: feeds pending column indexes, predicts at acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid     <= 1'b0;
            i_column_index <= '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expand_taps(i_column_index);
                item_cnt++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_idx.size() > 0 && $urandom_range(99) >= send_idle) begin
                    i_in_valid     <= 1'b1;
                    i_column_index <= pending_idx.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back-pressure and field-by-field compare
    always @(posedge i_clk) begin
        t_tap e;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                tap_cnt++;
                if (tap_q.size() == 0) begin
                    $error("unexpected result transaction, src=%h dst=%h",
                           o_source_address, o_dest_address);
                    fail_cnt++;
                end else begin
                    e = tap_q.pop_front();
                    if (o_source_address !== e.src) begin
                        $error("source_address exp %h got %h", e.src, o_source_address);
                        fail_cnt++;
                    end
                    if (o_pad_zero !== e.pad) begin
                        $error("pad_zero exp %b got %b", e.pad, o_pad_zero);
                        fail_cnt++;
                    end
                    if (o_dest_address !== e.dst) begin
                        $error("dest_address exp %h got %h", e.dst, o_dest_address);
                        fail_cnt++;
                    end
                    if (o_out_of_range !== e.oor) begin
                        $error("out_of_range exp %b got %b", e.oor, o_out_of_range);
                        fail_cnt++;
                    end
                    if (o_last_tap !== e.last) begin
                        $error("last_tap exp %b got %b", e.last, o_last_tap);
                        fail_cnt++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    // watchdog on cycles with no transaction on any port
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we
            || !i_rst_n) begin
            idle_cnt = 0;
        end else begin
            idle_cnt++;
        end
        if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", tap_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            REG_IMAGE_HEIGHT:  img_h = data[DIM_W-1:0];
            REG_IMAGE_WIDTH:   img_w = data[DIM_W-1:0];
            REG_KERNEL_HEIGHT: ker_h = data[KER_W-1:0];
            REG_KERNEL_WIDTH:  ker_w = data[KER_W-1:0];
            REG_PAD_ROWS:      pad_r = data[PAD_W-1:0];
            REG_PAD_COLS:      pad_c = data[PAD_W-1:0];
            REG_STRIDE_ROWS:   str_r = data[STR_W-1:0];
            default:           str_c = data[STR_W-1:0];
        endcase
        cfg_cnt++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(int h, int w, int kh, int kw, int pr, int pc,
                                int sr, int sc);
        cfg_write(REG_IMAGE_HEIGHT,  CFG_W'(h));
        cfg_write(REG_IMAGE_WIDTH,   CFG_W'(w));
        cfg_write(REG_KERNEL_HEIGHT, CFG_W'(kh));
        cfg_write(REG_KERNEL_WIDTH,  CFG_W'(kw));
        cfg_write(REG_PAD_ROWS,      CFG_W'(pr));
        cfg_write(REG_PAD_COLS,      CFG_W'(pc));
        cfg_write(REG_STRIDE_ROWS,   CFG_W'(sr));
        cfg_write(REG_STRIDE_COLS,   CFG_W'(sc));
    endtask

    // wait until every queued index is taken and every tap has come back
    task automatic drain();
        while (pending_idx.size() > 0 || i_in_valid || tap_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // corner indexes of the current grid
    task automatic push_corners();
        longint total;
        total = CHANNELS * IMAGES * rows_out() * cols_out();
        pending_idx.push_back('0);
        pending_idx.push_back(IDX_W'(total));
        pending_idx.push_back('1);
        if (total > 0) begin
            pending_idx.push_back(IDX_W'(total - 1));
            pending_idx.push_back(IDX_W'(cols_out() - 1));
        end
    endtask

    function automatic logic [IDX_W-1:0] rand_index();
        longint total;
        int     sel;
        total = CHANNELS * IMAGES * rows_out() * cols_out();
        sel = $urandom_range(9);
        if (total == 0 || sel == 8) return $urandom();
        if (sel == 9) return IDX_W'(total + $urandom_range(3));
        return IDX_W'(longint'($urandom()) % total);
    endfunction

    // mostly small grids, now and then the extremes
    task automatic random_geometry();
        int h, w;
        h = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(1, 24);
        w = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(1, 24);
        set_geometry(h, w,
                     ($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(1, 5),
                     ($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(1, 5),
                     ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(3),
                     ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(3),
                     ($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(1, 3),
                     ($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(1, 3));
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        img_h = 32; img_w = 32; ker_h = 3; ker_w = 3;
        pad_r = 1;  pad_c = 1;  str_r = 1; str_c = 1;
        send_idle = 8;
        recv_idle = 71;
        fail_cnt = 0; item_cnt = 0; tap_cnt = 0; cfg_cnt = 0; idle_cnt = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry corners
        push_corners();
        drain();

        // kernel wider than the padded image: everything out of range
        set_geometry(1, 1, 8, 8, 0, 0, 1, 1);
        push_corners();
        drain();

        // largest image, zero kernel and zero stride, maximum padding
        set_geometry(4095, 4095, 0, 0, 255, 255, 0, 0);
        push_corners();
        pending_idx.push_back(32'h1234_5678);
        drain();

        // oversized kernel saturates, widest stride, tiny image
        set_geometry(3, 5, 15, 9, 2, 0, 31, 16);
        push_corners();
        drain();

        // full 8x8 kernel over a small padded image
        set_geometry(4, 4, 8, 8, 3, 3, 2, 1);
        push_corners();
        drain();

        // random phases, idling pattern changes every two phases
        for (int ph = 0; ph < 6; ph++) begin
            send_idle = (ph < 2) ? 8 : (ph < 4) ? 71 : 0;
            recv_idle = (ph < 2) ? 71 : (ph < 4) ? 8 : 0;
            random_geometry();
            for (int n = 0; n < 37; n++)
                pending_idx.push_back(rand_index());
            drain();
        end

        $display("covered %0d column indexes, %0d tap results, %0d register writes",
                 item_cnt, tap_cnt, cfg_cnt);
        $display("geometry ran from degenerate grids to 4095x4095 with 1x1 to 8x8 kernels");
        if (fail_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/im2col_pkg.sv
design/im2col_divpipe.sv
design/im2col_cfg.sv
design/im2col_address_generator.sv
tb/sv/tb_im2col_address_generator.sv
